// ===== rtl/lcbc_pkg.sv =====
`default_nettype none

package lcbc_pkg;

  localparam int InWidth     = 54;
  localparam int BcdDigits   = 17;
  localparam int BcdWidth    = 4 * BcdDigits;
  localparam int BitsPerStep = 3;
  localparam int ConvSteps   = InWidth / BitsPerStep;
  localparam int ConvCntW    = $clog2(ConvSteps);
  localparam int CountW      = 5;

  // Longest number that may still pass, and the lengths that are accepted.
  localparam logic [CountW-1:0] MaxDigits = CountW'(16);
  localparam logic [CountW-1:0] LenShort  = CountW'(13);
  localparam logic [CountW-1:0] LenMid    = CountW'(15);
  localparam logic [CountW-1:0] LenLong   = CountW'(16);

  localparam logic [3:0] DigitTen = 4'd10;

  typedef enum logic [1:0] {
    VERDICT_INVALID = 2'd0,
    VERDICT_PFX4    = 2'd1,
    VERDICT_PFX3X   = 2'd2,
    VERDICT_PFX5X   = 2'd3
  } verdict_t;

  typedef struct packed {
    logic start_conv;
    logic start_scan;
  } ctl_t;

  typedef struct packed {
    logic                done;
    logic [BcdWidth-1:0] bcd;
  } conv_st_t;

  typedef struct packed {
    logic              done;
    logic [CountW-1:0] count;
    logic              sum_ok;
    logic [3:0]        lead_hi;
    logic [3:0]        lead_lo;
  } scan_st_t;

  // One double-dabble step: correct every digit, then shift in one bit.
  function automatic logic [BcdWidth-1:0] dabble(input logic [BcdWidth-1:0] bcd,
                                                 input logic              bin);
    logic [BcdWidth-1:0] adj;
    adj = bcd;
    for (int i = 0; i < BcdDigits; i++) begin
      if (adj[4*i +: 4] > 4'd4) begin
        adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
      end
    end
    return {adj[BcdWidth-2:0], bin};
  endfunction

  // Doubled digit folded back to one digit by adding its two digits.
  function automatic logic [3:0] luhn_double(input logic [3:0] d);
    logic [4:0] t;
    t = {d, 1'b0};
    if (t > 5'd9) begin
      t = t - 5'd9;
    end
    return t[3:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lcbc_if.sv =====
`default_nettype none

interface lcbc_in_if;
  logic                            valid;
  logic                            ready;
  logic [lcbc_pkg::InWidth-1:0]    card_number;

  modport source (output valid, output card_number, input ready);
  modport sink   (input valid, input card_number, output ready);
endinterface

interface lcbc_out_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      verdict;
  logic                            checksum_ok;
  logic [lcbc_pkg::CountW-1:0]     digit_count;

  modport source (output valid, output verdict, output checksum_ok, output digit_count,
                  input ready);
  modport sink   (input valid, input verdict, input checksum_ok, input digit_count,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/lcbc_bcd_conv.sv =====
`default_nettype none

module lcbc_bcd_conv (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire lcbc_pkg::ctl_t               ctl,
  input  wire logic [lcbc_pkg::InWidth-1:0] value,
  output lcbc_pkg::conv_st_t                st
);

  logic [lcbc_pkg::InWidth-1:0]  val_r, val_nxt;
  logic [lcbc_pkg::BcdWidth-1:0] bcd_r, bcd_nxt;
  logic [lcbc_pkg::ConvCntW-1:0] cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;

  always_comb begin
    logic [lcbc_pkg::BcdWidth-1:0] b;
    val_nxt  = val_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    b        = bcd_r;
    if (ctl.start_conv) begin
      val_nxt  = value;
      bcd_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // Several binary bits enter the BCD register per cycle, most significant first.
      for (int k = 0; k < lcbc_pkg::BitsPerStep; k++) begin
        b = lcbc_pkg::dabble(b, val_r[lcbc_pkg::InWidth-1-k]);
      end
      bcd_nxt = b;
      val_nxt = val_r << lcbc_pkg::BitsPerStep;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == lcbc_pkg::ConvCntW'(lcbc_pkg::ConvSteps - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    val_r <= val_nxt;
    bcd_r <= bcd_nxt;
  end

  assign st.done = done_r;
  assign st.bcd  = bcd_r;

endmodule

`default_nettype wire

// ===== rtl/lcbc_luhn_scan.sv =====
`default_nettype none

module lcbc_luhn_scan (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lcbc_pkg::ctl_t                ctl,
  input  wire logic [lcbc_pkg::BcdWidth-1:0] bcd_in,
  output lcbc_pkg::scan_st_t                 st
);

  logic [lcbc_pkg::BcdWidth-1:0] bcd_r, bcd_nxt;
  logic [lcbc_pkg::CountW-1:0]   count_r, count_nxt;
  logic [3:0]                    sum_r, sum_nxt;
  logic [3:0]                    lead_hi_r, lead_hi_nxt;
  logic [3:0]                    lead_lo_r, lead_lo_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;

  always_comb begin
    logic [3:0] d;
    logic [4:0] s;
    bcd_nxt     = bcd_r;
    count_nxt   = count_r;
    sum_nxt     = sum_r;
    lead_hi_nxt = lead_hi_r;
    lead_lo_nxt = lead_lo_r;
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    d           = bcd_r[3:0];
    // Odd positions from the right are the doubled ones.
    if (count_r[0]) begin
      d = lcbc_pkg::luhn_double(bcd_r[3:0]);
    end
    s = {1'b0, sum_r} + {1'b0, d};
    if (ctl.start_scan) begin
      bcd_nxt     = bcd_in;
      count_nxt   = '0;
      sum_nxt     = '0;
      lead_hi_nxt = '0;
      lead_lo_nxt = '0;
      busy_nxt    = 1'b1;
    end else if (busy_r) begin
      if (bcd_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        // The sum is kept modulo ten as it runs.
        sum_nxt     = (s >= {1'b0, lcbc_pkg::DigitTen}) ?
                      s[3:0] - lcbc_pkg::DigitTen : s[3:0];
        count_nxt   = count_r + 1'b1;
        lead_hi_nxt = bcd_r[3:0];
        lead_lo_nxt = lead_hi_r;
        bcd_nxt     = bcd_r >> 4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    bcd_r     <= bcd_nxt;
    count_r   <= count_nxt;
    sum_r     <= sum_nxt;
    lead_hi_r <= lead_hi_nxt;
    lead_lo_r <= lead_lo_nxt;
  end

  assign st.done    = done_r;
  assign st.count   = count_r;
  assign st.sum_ok  = (sum_r == 4'd0);
  assign st.lead_hi = lead_hi_r;
  assign st.lead_lo = lead_lo_r;

endmodule

`default_nettype wire

// ===== rtl/luhn_card_brand_check.sv =====
// Flow: the accepted number is converted to BCD, then its digits are scanned for the
// Luhn sum, the digit count (0 to 17) and the leading pair; the verdict is registered.
// Items are handled one at a time: a new number is accepted only in idle, once the last
// result has been loaded into the output register.
// Reset (rst_n, synchronous, active low) empties the result register and returns the
// sequencer to idle; no state is carried between items.
`default_nettype none

module luhn_card_brand_check (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lcbc_in_if.sink     in_ch,
  lcbc_out_if.source  out_ch
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  lcbc_pkg::ctl_t     ctl;
  lcbc_pkg::conv_st_t conv_st;
  lcbc_pkg::scan_st_t scan_st;

  logic                          out_valid_r, out_valid_nxt;
  lcbc_pkg::verdict_t            out_verdict_r;
  logic                          out_ok_r;
  logic [lcbc_pkg::CountW-1:0]   out_count_r;
  lcbc_pkg::verdict_t            verdict;
  logic                          len_ok;
  logic                          load_out;

  lcbc_bcd_conv u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .value (in_ch.card_number),
    .st    (conv_st)
  );

  lcbc_luhn_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .bcd_in (conv_st.bcd),
    .st     (scan_st)
  );

  assign in_ch.ready = (state_r == S_IDLE);

  assign ctl.start_conv = (state_r == S_IDLE) && in_ch.valid;
  assign ctl.start_scan = (state_r == S_CONV) && conv_st.done;

  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_ch.valid) state_nxt = S_CONV;
      S_CONV: if (conv_st.done) state_nxt = S_SCAN;
      S_SCAN: if (scan_st.done) state_nxt = S_DONE;
      S_DONE: if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign len_ok = (scan_st.count <= lcbc_pkg::MaxDigits) &&
                  ((scan_st.count == lcbc_pkg::LenShort) ||
                   (scan_st.count == lcbc_pkg::LenMid) ||
                   (scan_st.count == lcbc_pkg::LenLong));

  // Prefix classes are tried in order; the first match wins.
  always_comb begin
    verdict = lcbc_pkg::VERDICT_INVALID;
    if (scan_st.sum_ok && len_ok) begin
      if (scan_st.lead_hi == 4'd4) begin
        verdict = lcbc_pkg::VERDICT_PFX4;
      end else if (scan_st.lead_hi == 4'd3 &&
                   (scan_st.lead_lo == 4'd4 || scan_st.lead_lo == 4'd7)) begin
        verdict = lcbc_pkg::VERDICT_PFX3X;
      end else if (scan_st.lead_hi == 4'd5 &&
                   scan_st.lead_lo >= 4'd1 && scan_st.lead_lo <= 4'd5) begin
        verdict = lcbc_pkg::VERDICT_PFX5X;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (load_out) begin
      out_verdict_r <= verdict;
      out_ok_r      <= scan_st.sum_ok;
      out_count_r   <= scan_st.count;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.verdict     = out_verdict_r;
  assign out_ch.checksum_ok = out_ok_r;
  assign out_ch.digit_count = out_count_r;

  a_accept_starts_conv : assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == S_CONV))
    else $error("accepted item did not start the conversion");

  a_conv_done_in_conv : assert property (@(posedge clk) disable iff (!rst_n)
    conv_st.done |-> (state_r == S_CONV))
    else $error("conversion finished outside the conversion phase");

  a_scan_done_in_scan : assert property (@(posedge clk) disable iff (!rst_n)
    scan_st.done |-> (state_r == S_SCAN))
    else $error("digit scan finished outside the scan phase");

  a_valid_verdict_needs_checks : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_verdict_r != lcbc_pkg::VERDICT_INVALID)) |->
      (out_ok_r && ((out_count_r == lcbc_pkg::LenShort) ||
                    (out_count_r == lcbc_pkg::LenMid) ||
                    (out_count_r == lcbc_pkg::LenLong))))
    else $error("brand verdict given without checksum and length");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int InWidth      = lcbc_pkg::InWidth;
  localparam int CountW       = lcbc_pkg::CountW;

  localparam int CycleLimit   = 1_000_000;
  localparam int DrainCycles  = 60;
  localparam int RandomItems  = 1000;
  localparam int StallCycles  = 400;
  localparam int ScanLimit    = 20;

  // Leading digits that select each class, and near misses that select none.
  localparam int LeadFour     = 4;
  localparam int LeadPairA    = 34;
  localparam int LeadPairB    = 37;
  localparam int LeadPairLo   = 51;
  localparam int LeadPairHi   = 55;
  localparam int NearLeads[6] = '{33, 35, 36, 38, 50, 56};

  typedef struct {
    logic [InWidth-1:0] card;
    lcbc_pkg::verdict_t verdict;
    logic               sum_ok;
    logic [CountW-1:0]  count;
  } card_verdict_t;

  logic clk = 1'b0;
  logic rst_n;
  logic sink_ready = 1'b0;

  lcbc_in_if  in_ch ();
  lcbc_out_if out_ch ();

  assign out_ch.ready = sink_ready;

  luhn_card_brand_check DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  card_verdict_t pending_verdicts[$];
  int            error_count  = 0;
  int            cycle_count  = 0;
  bit            no_idle      = 1'b0;
  int            hold_request = 0;
  int            hold_left    = 0;
  int            ready_gap    = 0;

  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  function automatic void luhn_digest(input logic [InWidth-1:0] n,
                                      output int unsigned sum,
                                      output int unsigned count,
                                      output longint unsigned lead);
    longint unsigned rest;
    int unsigned     d;
    rest  = n;
    sum   = 0;
    count = 0;
    lead  = 0;
    for (int pos = 0; pos < ScanLimit && rest != 0; pos++) begin
      d = 32'(rest % 10);
      if (pos % 2 != 0) begin
        d = 2 * d;
        if (d > 9) d = d - 9;
      end
      sum   += d;
      count += 1;
      if (rest >= 10 && rest < 100) begin
        lead = rest;
      end else if (rest < 10 && lead == 0) begin
        lead = rest;
      end
      rest = rest / 10;
    end
  endfunction

  function automatic card_verdict_t judge_card(input logic [InWidth-1:0] n);
    card_verdict_t   res;
    int unsigned     sum;
    int unsigned     count;
    longint unsigned lead;
    luhn_digest(n, sum, count, lead);
    res.card    = n;
    res.sum_ok  = (sum % 10 == 0);
    res.count   = count[CountW-1:0];
    res.verdict = lcbc_pkg::VERDICT_INVALID;
    if (res.sum_ok && count <= lcbc_pkg::MaxDigits &&
        (count == lcbc_pkg::LenShort || count == lcbc_pkg::LenMid ||
         count == lcbc_pkg::LenLong)) begin
      if (lead / 10 == LeadFour) begin
        res.verdict = lcbc_pkg::VERDICT_PFX4;
      end else if (lead == LeadPairA || lead == LeadPairB) begin
        res.verdict = lcbc_pkg::VERDICT_PFX3X;
      end else if (lead >= LeadPairLo && lead <= LeadPairHi) begin
        res.verdict = lcbc_pkg::VERDICT_PFX5X;
      end
    end
    return res;
  endfunction

  // Builds a number of len digits (at least three) that starts with lead2
  // and ends in the digit that makes its Luhn sum a multiple of ten.
  function automatic logic [InWidth-1:0] make_card(input int len, input int lead2);
    longint unsigned v;
    int unsigned     sum;
    int unsigned     count;
    longint unsigned lead;
    v = lead2;
    for (int i = 2; i < len - 1; i++) v = v * 10 + $urandom_range(0, 9);
    luhn_digest(InWidth'(v * 10), sum, count, lead);
    return InWidth'(v * 10 + (10 - sum % 10) % 10);
  endfunction

  function automatic logic [InWidth-1:0] bump_check(input logic [InWidth-1:0] n);
    longint unsigned v;
    v = n;
    return InWidth'(v - v % 10 + (v % 10 + $urandom_range(1, 9)) % 10);
  endfunction

  function automatic int pick_lead();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return 40 + $urandom_range(0, 9);
    if (r == 3) return LeadPairA;
    if (r == 4) return LeadPairB;
    if (r < 7) return $urandom_range(LeadPairLo, LeadPairHi);
    if (r == 7) return NearLeads[$urandom_range(0, 5)];
    return $urandom_range(10, 99);
  endfunction

  function automatic int pick_length();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 12 + 2 * $urandom_range(0, 1);
    if (r < 4) return lcbc_pkg::LenShort;
    if (r < 7) return lcbc_pkg::LenMid;
    return lcbc_pkg::LenLong;
  endfunction

  function automatic logic [InWidth-1:0] random_card();
    int unsigned     pick;
    int              len;
    longint unsigned p;
    logic [63:0]     raw;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      if ($urandom_range(0, 19) == 0) return make_card(17, $urandom_range(10, 17));
      len = pick_length();
      return make_card(len, pick_lead());
    end
    if (pick < 70) begin
      return make_card($urandom_range(3, 16), $urandom_range(10, 99));
    end
    if (pick < 85) begin
      raw = {$urandom, $urandom};
      if ($urandom_range(0, 1) == 0) return raw[InWidth-1:0];
      p = 1;
      repeat ($urandom_range(1, 17)) p = p * 10;
      return InWidth'(raw[InWidth-1:0] % p);
    end
    return bump_check(make_card(pick_length(), pick_lead()));
  endfunction

  task automatic send_card(input logic [InWidth-1:0] n);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.card_number <= n;
    do @(posedge clk); while (!in_ch.ready);
    pending_verdicts.push_back(judge_card(n));
  endtask

  // Withdraws the input and waits until every result has come back.
  task automatic settle_results();
    in_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic test_special_cases();
    send_card('0);
    send_card(InWidth'(1));
    send_card(InWidth'(LeadFour));
    send_card(InWidth'(9));
    send_card(InWidth'(LeadPairA));
    send_card({InWidth{1'b1}});
    send_card(InWidth'(64'd10000000000000000));
    send_card(InWidth'(64'd9999999999999999));
    send_card(make_card(17, 10));
    // A leading 1 still counts toward the Luhn sum.
    send_card(make_card(16, 10));
    settle_results();
  endtask

  task automatic test_prefixes_and_lengths();
    send_card(make_card(lcbc_pkg::LenLong, 40 + $urandom_range(0, 9)));
    send_card(make_card(lcbc_pkg::LenShort, 40 + $urandom_range(0, 9)));
    send_card(make_card(lcbc_pkg::LenMid, 40 + $urandom_range(0, 9)));
    send_card(make_card(lcbc_pkg::LenMid, LeadPairA));
    send_card(make_card(lcbc_pkg::LenMid, LeadPairB));
    send_card(make_card(lcbc_pkg::LenLong, LeadPairLo));
    send_card(make_card(lcbc_pkg::LenLong, LeadPairHi));
    send_card(make_card(lcbc_pkg::LenShort, LeadPairLo));
    send_card(make_card(lcbc_pkg::LenLong, 50));
    send_card(make_card(lcbc_pkg::LenLong, 56));
    send_card(make_card(lcbc_pkg::LenLong, 33));
    send_card(make_card(14, 45));
    send_card(make_card(12, 45));
    send_card(bump_check(make_card(lcbc_pkg::LenLong, 45)));
    settle_results();
  endtask

  task automatic test_random_mix();
    repeat (RandomItems) send_card(random_card());
    settle_results();
  endtask

  task automatic test_full_rate();
    no_idle = 1'b1;
    repeat (40) send_card(random_card());
    settle_results();
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_request = StallCycles;
    repeat (10) send_card(make_card(pick_length(), pick_lead()));
    settle_results();
  endtask

  task automatic test_pause_midstream();
    repeat (15) send_card(random_card());
    settle_results();
    repeat (15) send_card(random_card());
    settle_results();
  endtask

  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (!rst_n) begin
      sink_ready <= 1'b0;
    end else if (hold_left > 0) begin
      sink_ready <= 1'b0;
      hold_left  = hold_left - 1;
    end else if (no_idle) begin
      sink_ready <= 1'b1;
    end else if (ready_gap > 0) begin
      sink_ready <= 1'b0;
      ready_gap  = ready_gap - 1;
    end else begin
      sink_ready <= 1'b1;
      ready_gap  = pick_gap();
    end
  end

  always @(posedge clk) begin : check_results
    card_verdict_t want;
    if (rst_n && out_ch.valid && sink_ready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result with nothing pending: verdict %0d ok %0d count %0d", $time,
                 out_ch.verdict, out_ch.checksum_ok, out_ch.digit_count);
        error_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_ch.verdict !== want.verdict) begin
          $display("%0t: card %0d verdict: expected %0d, got %0d", $time, want.card,
                   want.verdict, out_ch.verdict);
          error_count++;
        end
        if (out_ch.checksum_ok !== want.sum_ok) begin
          $display("%0t: card %0d checksum_ok: expected %0d, got %0d", $time, want.card,
                   want.sum_ok, out_ch.checksum_ok);
          error_count++;
        end
        if (out_ch.digit_count !== want.count) begin
          $display("%0t: card %0d digit_count: expected %0d, got %0d", $time, want.card,
                   want.count, out_ch.digit_count);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: run did not finish within %0d cycles", $time, CycleLimit);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.card_number <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_special_cases();
    test_prefixes_and_lengths();
    test_random_mix();
    test_full_rate();
    test_backpressure();
    test_pause_midstream();

    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
